[src/qmr_pkg.sv]
package qmr_pkg;

	// word format
	localparam int WORD_BITS     = 16;
	localparam int FRACTION_BITS = 14;

	// one extra bit holds the conjugate of the most negative word exactly
	localparam int OPND_BITS = WORD_BITS + 1;
	localparam int PROD_BITS = 2 * OPND_BITS;
	localparam int TERM_BITS = PROD_BITS - FRACTION_BITS;
	localparam int SUM_BITS  = TERM_BITS + 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// component positions
	localparam int CW = 0;
	localparam int CX = 1;
	localparam int CY = 2;
	localparam int CZ = 3;

	typedef enum logic {
		ACT_MULTIPLY = 1'b0,
		ACT_ROTATE   = 1'b1
	} action_t;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [OPND_BITS-1:0] opnd_t;
	typedef logic signed [TERM_BITS-1:0] term_t;
	typedef logic signed [SUM_BITS-1:0]  sum_t;

	typedef opnd_t [3:0]  quad_t;
	typedef word_t [3:0]  wquad_t;
	typedef term_t [15:0] terms_t;
	typedef sum_t [3:0]   sums_t;

	localparam logic signed [PROD_BITS-1:0] ROUND_BIAS =
		{{(PROD_BITS-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};
	localparam sum_t SAT_HI = {{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
	localparam sum_t SAT_LO = {{(SUM_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef struct packed {
		logic  action;
		word_t first_w;
		word_t first_x;
		word_t first_y;
		word_t first_z;
		word_t second_w;
		word_t second_x;
		word_t second_y;
		word_t second_z;
	} in_item_t;

	typedef struct packed {
		word_t result_w;
		word_t result_x;
		word_t result_y;
		word_t result_z;
		logic  saturated;
	} out_item_t;

	// classified work for the back end: first pass a*b, second pass t*c
	typedef struct packed {
		logic  rot;
		quad_t a;
		quad_t b;
		quad_t c;
	} job_t;

	typedef struct packed {
		logic                 full;
		logic                 avail;
		logic [QCNT_BITS-1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic  clip;
		word_t val;
	} sat_t;

	// exact product, round half up, drop fraction bits
	function automatic term_t mul_round(opnd_t a, opnd_t b);
		logic signed [PROD_BITS-1:0] p;
		p = a * b;
		p = p + ROUND_BIAS;
		return term_t'(p[PROD_BITS-1:FRACTION_BITS]);
	endfunction

	// Hamilton sums from rounded terms, term index 4*i+j = a[i]*b[j]
	function automatic sums_t ham_sums(terms_t p);
		sum_t  e [16];
		sums_t s;
		int    k;
		for (k = 0; k < 16; k++) begin
			e[k] = SUM_BITS'($signed(p[k]));
		end
		s[CW] = e[0] - e[5] - e[10] - e[15];
		s[CX] = e[1] + e[4] + e[11] - e[14];
		s[CY] = e[2] + e[8] + e[13] - e[7];
		s[CZ] = e[3] + e[12] + e[6] - e[9];
		return s;
	endfunction

	function automatic sat_t saturate(sum_t v);
		sat_t r;
		if (v > SAT_HI) begin
			r.clip = 1'b1;
			r.val  = WORD_MAX;
		end else if (v < SAT_LO) begin
			r.clip = 1'b1;
			r.val  = WORD_MIN;
		end else begin
			r.clip = 1'b0;
			r.val  = word_t'(v[WORD_BITS-1:0]);
		end
		return r;
	endfunction

	function automatic job_t classify(in_item_t it);
		job_t j;
		j.rot   = (it.action == ACT_ROTATE);
		j.a[CW] = OPND_BITS'(it.first_w);
		j.a[CX] = OPND_BITS'(it.first_x);
		j.a[CY] = OPND_BITS'(it.first_y);
		j.a[CZ] = OPND_BITS'(it.first_z);
		j.b[CW] = j.rot ? '0 : OPND_BITS'(it.second_w);
		j.b[CX] = OPND_BITS'(it.second_x);
		j.b[CY] = OPND_BITS'(it.second_y);
		j.b[CZ] = OPND_BITS'(it.second_z);
		j.c[CW] = j.a[CW];
		j.c[CX] = -j.a[CX];
		j.c[CY] = -j.a[CY];
		j.c[CZ] = -j.a[CZ];
		return j;
	endfunction

endpackage

[src/qmr_front.sv]
module qmr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  qmr_pkg::in_item_t item,
	input  qmr_pkg::q_stat_t  q_stat,
	output logic              push,
	output qmr_pkg::job_t     push_job
);
	import qmr_pkg::*;

	logic fr_valid_q;
	job_t fr_job_q;

	assign item_stall = fr_valid_q && q_stat.full;
	assign push       = fr_valid_q && !q_stat.full;
	assign push_job   = fr_job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_q <= 1'b0;
		end else if (!item_stall) begin
			fr_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			fr_job_q <= classify(item);
		end
	end

endmodule

[src/qmr_queue.sv]
module qmr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  qmr_pkg::job_t    push_job,
	input  logic             pop,
	output qmr_pkg::job_t    pop_job,
	output qmr_pkg::q_stat_t stat
);
	import qmr_pkg::*;

	job_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	function automatic logic [QPTR_BITS-1:0] ptr_next(logic [QPTR_BITS-1:0] p);
		if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign stat.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign stat.avail = (count_q != '0);
	assign stat.count = count_q;
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

[src/qmr_back.sv]
module qmr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_avail,
	input  qmr_pkg::job_t      job,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output qmr_pkg::out_item_t result
);
	import qmr_pkg::*;

	logic en;

	// stage 1: first-pass products
	logic   v_s1;
	logic   rot_s1;
	quad_t  c_s1;
	terms_t pp_s1;
	terms_t pp1;

	// stage 2: first-pass sums, saturated
	logic   v_s2;
	logic   rot_s2;
	quad_t  c_s2;
	wquad_t t_s2;
	logic   flag_s2;
	sums_t  sums1;
	wquad_t t1;
	logic   flag1;

	// stage 3: second-pass products
	logic   v_s3;
	logic   rot_s3;
	wquad_t t_s3;
	logic   flag_s3;
	terms_t pp_s3;
	terms_t pp2;

	// output register
	logic      out_valid_q;
	out_item_t out_q;
	sums_t     sums2;
	out_item_t res;

	assign en           = !(out_valid_q && result_stall);
	assign pop          = job_avail && en;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				pp1[4*i+j] = mul_round(job.a[i], job.b[j]);
				pp2[4*i+j] = mul_round(OPND_BITS'($signed(t_s2[i])), c_s2[j]);
			end
		end
	end

	always_comb begin
		sat_t s;
		sums1 = ham_sums(pp_s1);
		flag1 = 1'b0;
		for (int k = 0; k < 4; k++) begin
			s     = saturate(sums1[k]);
			t1[k] = s.val;
			flag1 = flag1 | s.clip;
		end
	end

	always_comb begin
		sat_t sx;
		sat_t sy;
		sat_t sz;
		sums2 = ham_sums(pp_s3);
		sx    = saturate(sums2[CX]);
		sy    = saturate(sums2[CY]);
		sz    = saturate(sums2[CZ]);
		if (rot_s3) begin
			// rotated vector; scalar of the second product is dropped and never flags
			res.result_w  = '0;
			res.result_x  = sx.val;
			res.result_y  = sy.val;
			res.result_z  = sz.val;
			res.saturated = flag_s3 | sx.clip | sy.clip | sz.clip;
		end else begin
			res.result_w  = t_s3[CW];
			res.result_x  = t_s3[CX];
			res.result_y  = t_s3[CY];
			res.result_z  = t_s3[CZ];
			res.saturated = flag_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1  <= job.rot;
			c_s1    <= job.c;
			pp_s1   <= pp1;
			rot_s2  <= rot_s1;
			c_s2    <= c_s1;
			t_s2    <= t1;
			flag_s2 <= flag1;
			rot_s3  <= rot_s2;
			t_s3    <= t_s2;
			flag_s3 <= flag_s2;
			pp_s3   <= pp2;
			out_q   <= res;
		end
	end

endmodule

[src/quaternion_multiply_rotate.sv]
// Fixed-point quaternion unit, signed Q2.14 words.
// Input channel (item_valid / item_stall / item): one transfer carries an action,
// a first quaternion q and a second operand. Action multiply returns q*p; action
// rotate returns (0, v') with v' = q*(0,v)*conj(q), v taken from the second x,y,z.
// Output channel (result_valid / result_stall / result): one transfer per item,
// in order, with a flag set when any component (including the rotation's
// intermediate product) was clipped to the 16-bit range.
// An input transfer reaches result_valid through the front register, the queue slot,
// two multiply stages, each followed by a sum stage, the second of which ends in the
// output register. Throughput: one item per cycle while result_stall is low, set by the
// 16 parallel 17x17 multipliers of each pass.
// Reset (arst_n low): all valid bits and queue pointers clear; no item is lost
// except those in flight. No clearing pass is needed.
// When result_stall is high and result_valid is set, the back pipeline freezes
// and holds the output; the front keeps taking transfers into its 2-entry queue
// and its own register, and raises item_stall only once the queue is full.
module quaternion_multiply_rotate (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  qmr_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output qmr_pkg::out_item_t result
);
	import qmr_pkg::*;

	q_stat_t q_stat;
	logic    push;
	job_t    push_job;
	logic    pop;
	job_t    pop_job;

	// front: takes transfers, decodes the action, builds operands and conjugate
	qmr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	// decoupling queue between front and back
	qmr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.stat    (q_stat)
	);

	// back: two Hamilton passes, rounding and saturation, output register
	qmr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_avail   (q_stat.avail),
		.job         (pop_job),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	// front may only hold off the source when the queue has no room
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> q_stat.full)
		else $error("item_stall raised while queue has room");

	// queue occupancy never exceeds its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue count overflow");

	// frozen back end must not draw from the queue
	a_no_pop_when_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> !pop)
		else $error("queue popped while output stalled");

endmodule

[bench/tb_quaternion_multiply_rotate.sv]
module tb_quaternion_multiply_rotate;

	import qmr_pkg::*;

	// nothing accepted on either channel for this long means the block is stuck
	localparam int WATCHDOG_LIMIT = 2000;
	// extra cycles after the last result, covering the pipeline with margin
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_ITEMS   = 400;
	localparam longint ROUND_HALF = longint'(1) << (FRACTION_BITS - 1);
	localparam longint SAT_MAX    = (longint'(1) << (WORD_BITS - 1)) - 1;
	localparam longint SAT_MIN    = -SAT_MAX - 1;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_stall;
	in_item_t   item         = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	out_item_t  result;

	// stimulus not yet offered, and rotated/multiplied values still owed by the block
	in_item_t   pending_items[$];
	out_item_t  expected_results[$];

	int items_total   = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int failures      = 0;
	int idle_cycles   = 0;
	int send_wait     = 0;
	int stall_left    = 0;
	int stall_next;
	// stretches in which a side does not idle at all
	int calm_in       = 0;
	int calm_out      = 0;

	quaternion_multiply_rotate dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: exact products, round half up, exact sums, then clip.
	// ------------------------------------------------------------------
	function automatic longint rmul(longint a, longint b);
		return (a * b + ROUND_HALF) >>> FRACTION_BITS;
	endfunction

	// unclipped Hamilton product a*b
	function automatic void hamilton_sums(input longint a[4], input longint b[4],
			output longint s[4]);
		s[0] = rmul(a[0], b[0]) - rmul(a[1], b[1]) - rmul(a[2], b[2]) - rmul(a[3], b[3]);
		s[1] = rmul(a[0], b[1]) + rmul(a[1], b[0]) + rmul(a[2], b[3]) - rmul(a[3], b[2]);
		s[2] = rmul(a[0], b[2]) + rmul(a[2], b[0]) + rmul(a[3], b[1]) - rmul(a[1], b[3]);
		s[3] = rmul(a[0], b[3]) + rmul(a[3], b[0]) + rmul(a[1], b[2]) - rmul(a[2], b[1]);
	endfunction

	function automatic longint clip_word(longint v, inout bit clipped);
		if (v > SAT_MAX) begin
			clipped = 1'b1;
			return SAT_MAX;
		end
		if (v < SAT_MIN) begin
			clipped = 1'b1;
			return SAT_MIN;
		end
		return v;
	endfunction

	function automatic out_item_t predict_result(in_item_t it);
		longint    q[4];
		longint    p[4];
		longint    t[4];
		longint    c[4];
		longint    s[4];
		longint    r[4];
		bit        clipped;
		out_item_t o;
		clipped = 1'b0;
		q[0] = $signed(it.first_w);
		q[1] = $signed(it.first_x);
		q[2] = $signed(it.first_y);
		q[3] = $signed(it.first_z);
		p[0] = $signed(it.second_w);
		p[1] = $signed(it.second_x);
		p[2] = $signed(it.second_y);
		p[3] = $signed(it.second_z);
		if (it.action == ACT_MULTIPLY) begin
			hamilton_sums(q, p, s);
			for (int k = 0; k < 4; k++)
				r[k] = clip_word(s[k], clipped);
		end else begin
			// t = q*(0,v), clipped per component before the second pass
			p[0] = 0;
			hamilton_sums(q, p, s);
			for (int k = 0; k < 4; k++)
				t[k] = clip_word(s[k], clipped);
			// conjugate kept wide: negating the most negative word stays exact
			c[0] = q[0];
			c[1] = -q[1];
			c[2] = -q[2];
			c[3] = -q[3];
			hamilton_sums(t, c, s);
			// w of the second pass is dropped and never flags
			r[0] = 0;
			for (int k = 1; k < 4; k++)
				r[k] = clip_word(s[k], clipped);
		end
		o.result_w  = word_t'(r[0]);
		o.result_x  = word_t'(r[1]);
		o.result_y  = word_t'(r[2]);
		o.result_z  = word_t'(r[3]);
		o.saturated = clipped;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_item(input action_t act, input int fw, input int fx, input int fy,
			input int fz, input int sw, input int sx, input int sy, input int sz);
		in_item_t it;
		it.action   = act;
		it.first_w  = word_t'(fw);
		it.first_x  = word_t'(fx);
		it.first_y  = word_t'(fy);
		it.first_z  = word_t'(fz);
		it.second_w = word_t'(sw);
		it.second_x = word_t'(sx);
		it.second_y = word_t'(sy);
		it.second_z = word_t'(sz);
		pending_items.push_back(it);
	endtask

	// mostly in-range values near unit scale, plus full-range and the extremes
	function automatic int rand_word();
		case ($urandom_range(0, 7))
			0:       return 32767;
			1:       return -32768;
			2, 3:    return int'($urandom_range(0, 65535)) - 32768;
			default: return int'($urandom_range(0, 23170)) - 11585;
		endcase
	endfunction

	// idle cycles before the next transfer; occasionally a run of back-to-back ones
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			calm = $urandom_range(10, 30);
		return $urandom_range(0, 14);
	endfunction

	// ------------------------------------------------------------------
	// Driver: offers pending items, predicts each on its input transfer.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			send_wait  <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				expected_results.push_back(predict_result(item));
				items_sent <= items_sent + 1;
			end
			// a stalled transfer holds valid and payload untouched
			if (!(item_valid && item_stall)) begin
				if (send_wait != 0) begin
					send_wait  <= send_wait - 1;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item       <= pending_items.pop_front();
					item_valid <= 1'b1;
					send_wait  <= draw_wait(calm_in);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks every result transfer against the oldest expectation,
	// then stalls for a freshly drawn number of valid cycles.
	// ------------------------------------------------------------------
	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (expected_results.size() == 0) begin
			$error("result transfer with no item outstanding");
			failures++;
			return;
		end
		want = expected_results.pop_front();
		if (got.result_w !== want.result_w) begin
			$error("result_w: expected %0d, got %0d", want.result_w, got.result_w);
			failures++;
		end
		if (got.result_x !== want.result_x) begin
			$error("result_x: expected %0d, got %0d", want.result_x, got.result_x);
			failures++;
		end
		if (got.result_y !== want.result_y) begin
			$error("result_y: expected %0d, got %0d", want.result_y, got.result_y);
			failures++;
		end
		if (got.result_z !== want.result_z) begin
			$error("result_z: expected %0d, got %0d", want.result_z, got.result_z);
			failures++;
		end
		if (got.saturated !== want.saturated) begin
			$error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end else begin
			stall_next = stall_left;
			if (result_valid && !result_stall) begin
				check_result(result);
				results_seen <= results_seen + 1;
				stall_next = draw_wait(calm_out);
			end else if (result_valid && stall_next > 0) begin
				stall_next--;
			end
			stall_left   <= stall_next;
			result_stall <= (stall_next != 0);
		end
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// ------------------------------------------------------------------
	// Sequence: directed corners, random items, reset, drain, verdict.
	// ------------------------------------------------------------------
	initial begin
		// identity times identity
		queue_item(ACT_MULTIPLY, 16384, 0, 0, 0, 16384, 0, 0, 0);
		// field extremes and all zeros; every item but the zero one clips
		queue_item(ACT_MULTIPLY, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		queue_item(ACT_MULTIPLY, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768);
		queue_item(ACT_MULTIPLY, 32767, 32767, 32767, 32767,
			-32768, -32768, -32768, -32768);
		queue_item(ACT_MULTIPLY, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_item(ACT_MULTIPLY, 32767, 0, 0, 0, -32768, 0, 0, 0);
		queue_item(ACT_MULTIPLY, 0, -32768, -32768, -32768, 0, -32768, -32768, -32768);
		// exact half-LSB products: ties go toward +infinity
		queue_item(ACT_MULTIPLY, 1, 0, 0, 0, 8192, 8192, -8192, 0);
		queue_item(ACT_MULTIPLY, -1, 0, 0, 0, 8192, -8192, 8192, -8192);
		queue_item(ACT_MULTIPLY, 3, -3, 3, -3, 24576, 24576, -24576, 8192);
		// rotation by identity, second_w must be ignored
		queue_item(ACT_ROTATE, 16384, 0, 0, 0, -32768, 32767, -32768, 0);
		queue_item(ACT_ROTATE, 16384, 0, 0, 0, 32767, 1, -1, 32767);
		// conjugate of the most negative word
		queue_item(ACT_ROTATE, 0, -32768, 0, 0, 0, 16384, 16384, 16384);
		queue_item(ACT_ROTATE, 0, 0, 0, -32768, 0, 0, 16384, 0);
		// intermediate clipping
		queue_item(ACT_ROTATE, -32768, -32768, -32768, -32768, 0, 32767, 32767, 32767);
		queue_item(ACT_ROTATE, 32767, 32767, 32767, 32767, 5, -32768, -32768, -32768);
		queue_item(ACT_ROTATE, 0, 16384, 0, 0, 0, -32768, 32767, -32768);
		// quarter turn about z
		queue_item(ACT_ROTATE, 11585, 0, 0, 11585, 0, 16384, 0, 0);
		// non-unit q, applied without normalizing
		queue_item(ACT_ROTATE, 8192, 0, 0, 0, 0, 16384, -16384, 8192);
		queue_item(ACT_ROTATE, 0, 0, 0, 0, 0, 0, 0, 0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			queue_item($urandom_range(0, 1) ? ACT_ROTATE : ACT_MULTIPLY,
				rand_word(), rand_word(), rand_word(), rand_word(),
				rand_word(), rand_word(), rand_word(), rand_word());
		end
		items_total = pending_items.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait ((items_sent == items_total && results_seen == items_total)
			|| idle_cycles >= WATCHDOG_LIMIT);
		if (idle_cycles < WATCHDOG_LIMIT)
			repeat (DRAIN_CYCLES) @(posedge clk);

		if (idle_cycles < WATCHDOG_LIMIT && failures == 0 && expected_results.size() == 0)
			$display("[quaternion_multiply_rotate] OK");
		else
			$display("[quaternion_multiply_rotate] ERROR");
		$finish;
	end

endmodule
